[rtl/core/pidlpc_pkg.sv]
// Package for the PID controller with output smoothing and clamps.
// Holds the configuration register map, reset values, shared types and the controller states.
// No dependencies.
package pidlpc_pkg;

  // Default sample width of the error and drive words.
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration field widths.
  localparam int GAIN_W  = 16;
  localparam int BOUND_W = 15;
  localparam int ALPHA_W = 17;

  // Configuration write port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd5;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd4096;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd410;
  localparam logic [GAIN_W-1:0]  KD_RST    = 16'd819;
  localparam logic [BOUND_W-1:0] ILIM_RST  = 15'd768;
  localparam logic [BOUND_W-1:0] OLIM_RST  = 15'd2560;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd13107;

  // Alpha of exactly one in Q1.16.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [BOUND_W-1:0] ilim;
    logic [BOUND_W-1:0] olim;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_P,
    MSEL_I,
    MSEL_D,
    MSEL_F
  } msel_t;

  // Controller steps, one per cycle of work on a request; the filter step may wait.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_RAW,
    S_MUL_F,
    S_FILT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_e;
    logic  integ_en;
    logic  mul_en;
    msel_t mul_sel;
    logic  acc_ld;
    logic  acc_add;
    logic  diff_en;
    logic  filt_en;
  } dp_cmd_t;

endpackage

[rtl/core/pid_with_lowpass_and_clamps.sv]
// Top level of the PID controller with anti-windup, output low-pass filter and output clamp.
// Instantiates pidlpc_regs, pidlpc_ctrl and pidlpc_dp; depends on pidlpc_pkg.
//
// Each request carries one signed Q8.8 error sample and yields one signed Q8.8 drive value
// with a flag that is set when the output bound changed the filtered value. A request is
// taken only while the block is idle, and its result is loaded into the output register
// after the accept, the integral step, four multiplier passes with their accumulation,
// rounding and the filter step, so the block takes no new request until the last one
// has left its filter step; this is set by the single shared 17 by SAMPLE_WIDTH+1 bit
// multiplier, which forms the three gain products and the filter product in turn. A waiting
// result does not block the next request; only the filter step of the following request
// waits for the output register to empty. The user must write the configuration registers
// through the cfg_ port only while no request is in progress; the block does not enforce it.
module pid_with_lowpass_and_clamps #(
  parameter int SAMPLE_WIDTH = pidlpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_error_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_drive_value,
  output logic                                 out_output_clamped,
  input  logic                                 cfg_we,
  input  logic [pidlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidlpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  pidlpc_pkg::cfg_t    cfg;
  pidlpc_pkg::dp_cmd_t cmd;

  // Configuration registers.
  pidlpc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer.
  pidlpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic.
  pidlpc_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_error_sample    (in_error_sample),
    .out_drive_value    (out_drive_value),
    .out_output_clamped (out_output_clamped)
  );

endmodule

[rtl/core/pidlpc_regs.sv]
// Configuration register file of the PID controller.
// Depends on pidlpc_pkg for the register map, widths and reset values.
module pidlpc_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pidlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidlpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pidlpc_pkg::cfg_t                     cfg
);

  pidlpc_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode a write into the addressed field; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pidlpc_pkg::REG_KP:    cfg_nxt.kp    = cfg_wdata[pidlpc_pkg::GAIN_W-1:0];
        pidlpc_pkg::REG_KI:    cfg_nxt.ki    = cfg_wdata[pidlpc_pkg::GAIN_W-1:0];
        pidlpc_pkg::REG_KD:    cfg_nxt.kd    = cfg_wdata[pidlpc_pkg::GAIN_W-1:0];
        pidlpc_pkg::REG_ILIM:  cfg_nxt.ilim  = cfg_wdata[pidlpc_pkg::BOUND_W-1:0];
        pidlpc_pkg::REG_OLIM:  cfg_nxt.olim  = cfg_wdata[pidlpc_pkg::BOUND_W-1:0];
        pidlpc_pkg::REG_ALPHA: cfg_nxt.alpha = cfg_wdata[pidlpc_pkg::ALPHA_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register storage with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp    <= pidlpc_pkg::KP_RST;
      cfg_r.ki    <= pidlpc_pkg::KI_RST;
      cfg_r.kd    <= pidlpc_pkg::KD_RST;
      cfg_r.ilim  <= pidlpc_pkg::ILIM_RST;
      cfg_r.olim  <= pidlpc_pkg::OLIM_RST;
      cfg_r.alpha <= pidlpc_pkg::ALPHA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/pidlpc_dp.sv]
// Datapath of the PID controller: integral, derivative, one shared multiplier, accumulator,
// low-pass filter and output clamp. Depends on pidlpc_pkg for the command and config types.
module pidlpc_dp #(
  parameter int SAMPLE_WIDTH = pidlpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pidlpc_pkg::dp_cmd_t            cmd,
  input  pidlpc_pkg::cfg_t               cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] in_error_sample,
  output logic signed [SAMPLE_WIDTH-1:0] out_drive_value,
  output logic                           out_output_clamped
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = SW + 1;                        // derivative and filter difference
  localparam int PW    = pidlpc_pkg::ALPHA_W + 1 + DW;  // product width
  localparam int AW    = PW + 2;                        // sum of three products
  localparam int RW    = AW - 12;                       // accumulator after the Q.20 to Q8.8 shift
  localparam int QW    = PW - 16;                       // filter product after the Q0.16 shift
  localparam int FW    = QW + 1;                        // filter sum
  localparam int BND_W = ((SW > pidlpc_pkg::BOUND_W) ? SW : pidlpc_pkg::BOUND_W) + 1;

  // Largest positive sample value and the effective bound of a 15-bit register.
  function automatic logic [SW-2:0] bound_eff(input logic [pidlpc_pkg::BOUND_W-1:0] b);
    logic [BND_W-1:0] bx;
    logic [BND_W-1:0] mx;
    bx = BND_W'(b);
    mx = BND_W'({(SW-1){1'b1}});
    return (bx > mx) ? mx[SW-2:0] : bx[SW-2:0];
  endfunction

  // Symmetric clamp of a value one bit wider than a sample.
  function automatic logic signed [SW-1:0] clamp_sym(input logic signed [DW-1:0] x,
                                                     input logic [SW-2:0] lim);
    logic signed [DW-1:0] pos;
    logic signed [DW-1:0] neg;
    pos = $signed({2'b00, lim});
    neg = -pos;
    if (x > pos) begin
      return pos[SW-1:0];
    end else if (x < neg) begin
      return neg[SW-1:0];
    end else begin
      return x[SW-1:0];
    end
  endfunction

  logic signed [SW-1:0] e_r;
  logic signed [SW-1:0] integral_r, integral_nxt;
  logic signed [SW-1:0] prev_r;
  logic signed [DW-1:0] deriv_r;
  logic signed [DW-1:0] diff_r, diff_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] filt_r, filt_nxt;
  logic signed [SW-1:0] drive_r, drive_nxt;
  logic                 clamped_r;

  logic signed [DW-1:0] integ_sum;
  logic signed [DW-1:0] deriv_nxt;
  logic [pidlpc_pkg::ALPHA_W-1:0] alpha_eff;
  logic [pidlpc_pkg::ALPHA_W-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic signed [AW-1:0] acc_rnd;
  logic signed [RW-1:0] raw_wide;
  logic signed [SW-1:0] raw_sat;
  logic signed [PW-1:0] prod_rnd;
  logic signed [QW-1:0] filt_q;
  logic signed [FW-1:0] filt_sum;

  // Integral with anti-windup clamp, and the exact derivative.
  always_comb begin
    integ_sum    = DW'(integral_r) + DW'(e_r);
    integral_nxt = clamp_sym(integ_sum, bound_eff(cfg.ilim));
    deriv_nxt    = DW'(e_r) - DW'(prev_r);
  end

  // Shared multiplier: unsigned gain or alpha times a signed operand.
  always_comb begin
    alpha_eff = cfg.alpha[pidlpc_pkg::ALPHA_W-1] ? pidlpc_pkg::ALPHA_ONE : cfg.alpha;
    case (cmd.mul_sel)
      pidlpc_pkg::MSEL_P: begin
        op_a = pidlpc_pkg::ALPHA_W'(cfg.kp);
        op_b = DW'(e_r);
      end
      pidlpc_pkg::MSEL_I: begin
        op_a = pidlpc_pkg::ALPHA_W'(cfg.ki);
        op_b = DW'(integral_r);
      end
      pidlpc_pkg::MSEL_D: begin
        op_a = pidlpc_pkg::ALPHA_W'(cfg.kd);
        op_b = deriv_r;
      end
      pidlpc_pkg::MSEL_F: begin
        op_a = alpha_eff;
        op_b = diff_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_nxt = $signed({1'b0, op_a}) * op_b;
  end

  // Accumulate the three gain products.
  always_comb begin
    if (cmd.acc_ld) begin
      acc_nxt = AW'(prod_r);
    end else begin
      acc_nxt = acc_r + AW'(prod_r);
    end
  end

  // Round the raw drive half up to Q8.8, saturate, and form its distance from the history.
  always_comb begin
    acc_rnd  = acc_r + $signed(AW'(2048));
    raw_wide = acc_rnd[AW-1:12];
    if ((&raw_wide[RW-1:SW-1]) || !(|raw_wide[RW-1:SW-1])) begin
      raw_sat = raw_wide[SW-1:0];
    end else if (raw_wide[RW-1]) begin
      raw_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      raw_sat = {1'b0, {(SW-1){1'b1}}};
    end
    diff_nxt = DW'(raw_sat) - DW'(filt_r);
  end

  // Low-pass step: history plus rounded alpha times the difference, then saturate and clamp.
  always_comb begin
    prod_rnd = prod_r + $signed(PW'(32768));
    filt_q   = prod_rnd[PW-1:16];
    filt_sum = FW'(filt_q) + FW'(filt_r);
    if ((&filt_sum[FW-1:SW-1]) || !(|filt_sum[FW-1:SW-1])) begin
      filt_nxt = filt_sum[SW-1:0];
    end else if (filt_sum[FW-1]) begin
      filt_nxt = {1'b1, {(SW-1){1'b0}}};
    end else begin
      filt_nxt = {1'b0, {(SW-1){1'b1}}};
    end
    drive_nxt = clamp_sym(DW'(filt_nxt), bound_eff(cfg.olim));
  end

  // Controller state kept across requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
      filt_r     <= '0;
    end else begin
      if (cmd.integ_en) begin
        integral_r <= integral_nxt;
        prev_r     <= e_r;
      end
      if (cmd.filt_en) begin
        filt_r <= filt_nxt;
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.load_e) begin
      e_r <= in_error_sample;
    end
    if (cmd.integ_en) begin
      deriv_r <= deriv_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_ld || cmd.acc_add) begin
      acc_r <= acc_nxt;
    end
    if (cmd.diff_en) begin
      diff_r <= diff_nxt;
    end
    if (cmd.filt_en) begin
      drive_r   <= drive_nxt;
      clamped_r <= (drive_nxt != filt_nxt);
    end
  end

  assign out_drive_value    = drive_r;
  assign out_output_clamped = clamped_r;

endmodule

[rtl/core/pidlpc_ctrl.sv]
// Sequencer of the PID controller: steps the datapath through one request and owns
// both handshakes. Depends on pidlpc_pkg for the state and command types.
module pidlpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pidlpc_pkg::dp_cmd_t cmd
);

  pidlpc_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  // The result register may be loaded when empty or emptied at this edge.
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidlpc_pkg::S_IDLE:  if (in_valid) state_nxt = pidlpc_pkg::S_INTEG;
      pidlpc_pkg::S_INTEG: state_nxt = pidlpc_pkg::S_MUL_P;
      pidlpc_pkg::S_MUL_P: state_nxt = pidlpc_pkg::S_MUL_I;
      pidlpc_pkg::S_MUL_I: state_nxt = pidlpc_pkg::S_MUL_D;
      pidlpc_pkg::S_MUL_D: state_nxt = pidlpc_pkg::S_ACC_D;
      pidlpc_pkg::S_ACC_D: state_nxt = pidlpc_pkg::S_RAW;
      pidlpc_pkg::S_RAW:   state_nxt = pidlpc_pkg::S_MUL_F;
      pidlpc_pkg::S_MUL_F: state_nxt = pidlpc_pkg::S_FILT;
      pidlpc_pkg::S_FILT:  if (out_free) state_nxt = pidlpc_pkg::S_IDLE;
      default:             state_nxt = pidlpc_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and input stall for each step; no request is taken during reset.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = pidlpc_pkg::MSEL_P;
    in_stall    = !rst_n || (state_r != pidlpc_pkg::S_IDLE);
    case (state_r)
      pidlpc_pkg::S_IDLE:  cmd.load_e = in_valid;
      pidlpc_pkg::S_INTEG: cmd.integ_en = 1'b1;
      pidlpc_pkg::S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidlpc_pkg::MSEL_P;
      end
      pidlpc_pkg::S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidlpc_pkg::MSEL_I;
        cmd.acc_ld  = 1'b1;
      end
      pidlpc_pkg::S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidlpc_pkg::MSEL_D;
        cmd.acc_add = 1'b1;
      end
      pidlpc_pkg::S_ACC_D: cmd.acc_add = 1'b1;
      pidlpc_pkg::S_RAW:   cmd.diff_en = 1'b1;
      pidlpc_pkg::S_MUL_F: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidlpc_pkg::MSEL_F;
      end
      pidlpc_pkg::S_FILT:  cmd.filt_en = out_free;
      default:             cmd = '0;
    endcase
  end

  // Result valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    if (cmd.filt_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidlpc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted request starts the integral step next.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == pidlpc_pkg::S_INTEG))
    else $error("accepted request did not start the integral step");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.filt_en |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // A loaded result is offered at the next edge.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.filt_en |=> out_valid_r)
    else $error("loaded result not offered");

  // The last step waits while the result register is full and stalled.
  a_filt_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidlpc_pkg::S_FILT && !out_free) |=> (state_r == pidlpc_pkg::S_FILT))
    else $error("filter step left while output blocked");

  // At most one of the sample load, integral, accumulate, difference and filter commands is given per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_e, cmd.integ_en, cmd.acc_ld, cmd.acc_add, cmd.diff_en, cmd.filt_en}))
    else $error("overlapping datapath steps");
`endif

endmodule
